@@ hw/rtl/mprq_pkg.sv @@
// mprq_pkg: shared types and constants for the min-priority request queue.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package mprq_pkg;

    localparam int DATA_W  = 32;
    localparam int PRIO_W  = 32;
    localparam int WORD_W  = DATA_W + PRIO_W;
    localparam int COUNT_W = 7;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [DATA_W-1:0] NONE_DATA     = {DATA_W{1'b1}};
    localparam logic [PRIO_W-1:0] NONE_PRIORITY = {1'b0, {(PRIO_W-1){1'b1}}};

    // Controller to datapath
    typedef struct packed {
        logic enq_write;
        logic set_full;
        logic set_empty;
        logic scan_init;
        logic scan_cmp;
        logic rd_issue;
        logic shift_init;
        logic shift_write;
        logic deq_finish;
        logic emit;
    } mprq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic issue_done;
        logic rd_pending;
    } mprq_stat_t;

endpackage

@@ hw/rtl/mprq_dp.sv @@
// mprq_dp: entry memory, entry count, scan/shift read pipeline and result registers.
// Depends on mprq_pkg; driven by mprq_ctrl through mprq_cmd_t.
`timescale 1ns / 1ps

module mprq_dp
    import mprq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mprq_cmd_t                cmd,
    output mprq_stat_t               stat,
    input  logic signed [DATA_W-1:0] req_data,
    input  logic signed [PRIO_W-1:0] req_priority,
    output logic        [1:0]        status,
    output logic signed [DATA_W-1:0] out_data,
    output logic signed [PRIO_W-1:0] out_priority,
    output logic        [COUNT_W-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic [WORD_W-1:0] rd_word_reg;

    logic [AW-1:0]     best_idx_reg;
    logic [WORD_W-1:0] best_word_reg;

    logic [1:0]        res_status_reg;
    logic [DATA_W-1:0] res_data_reg;
    logic [PRIO_W-1:0] res_prio_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic              take_new;
    logic [CW+COUNT_W-1:0] count_ext;

    assign stat.full       = (count_reg == CW'(DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.issue_done = (ptr_reg == count_reg);
    assign stat.rd_pending = rd_vld_reg;

    // Write port: enqueue appends at the tail, shift moves each entry behind the winner down one slot
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = count_reg[AW-1:0];
        mem_wd = {req_data, req_priority};
        if (cmd.enq_write)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.shift_write && rd_vld_reg)
        begin
            mem_we = 1'b1;
            mem_wa = rd_idx_reg - AW'(1);
            mem_wd = rd_word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_word_reg <= mem[ptr_reg[AW-1:0]];
            rd_idx_reg  <= ptr_reg[AW-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq_write)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.deq_finish)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_init)
        begin
            ptr_next = '0;
        end
        else if (cmd.shift_init)
        begin
            ptr_next = CW'(best_idx_reg) + CW'(1);
        end
        else if (cmd.rd_issue)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= cmd.rd_issue;
        end
    end

    // Scan keeps the first entry, then takes only a strictly lower priority
    assign take_new = (rd_idx_reg == '0) ||
                      ($signed(rd_word_reg[PRIO_W-1:0]) < $signed(best_word_reg[PRIO_W-1:0]));

    always_ff @(posedge clk)
    begin
        if (cmd.scan_cmp && rd_vld_reg && take_new)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_word_reg <= rd_word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq_write)
        begin
            res_status_reg <= ST_DONE;
            res_data_reg   <= NONE_DATA;
            res_prio_reg   <= NONE_PRIORITY;
        end
        else if (cmd.set_full)
        begin
            res_status_reg <= ST_FULL;
            res_data_reg   <= NONE_DATA;
            res_prio_reg   <= NONE_PRIORITY;
        end
        else if (cmd.set_empty)
        begin
            res_status_reg <= ST_EMPTY;
            res_data_reg   <= NONE_DATA;
            res_prio_reg   <= NONE_PRIORITY;
        end
        else if (cmd.deq_finish)
        begin
            res_status_reg <= ST_DONE;
            res_data_reg   <= best_word_reg[WORD_W-1:PRIO_W];
            res_prio_reg   <= best_word_reg[PRIO_W-1:0];
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    // Output register: loaded only when the output slot is free
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status       <= res_status_reg;
            out_data     <= res_data_reg;
            out_priority <= res_prio_reg;
            count        <= count_ext[COUNT_W-1:0];
        end
    end

endmodule

@@ hw/rtl/mprq_ctrl.sv @@
// mprq_ctrl: operation sequencer for the min-priority request queue.
// Depends on mprq_pkg; drives mprq_dp through mprq_cmd_t and owns both handshakes.
`timescale 1ns / 1ps

module mprq_ctrl
    import mprq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    output logic       out_valid,
    input  logic       out_ready,
    input  mprq_stat_t stat,
    output mprq_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   pass_done;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign pass_done = stat.issue_done && !stat.rd_pending;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_ENQ)
                    begin
                        cmd.enq_write = !stat.full;
                        cmd.set_full  = stat.full;
                        state_next    = S_EMIT;
                    end
                    else if (stat.empty)
                    begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_cmp = 1'b1;
                cmd.rd_issue = !stat.issue_done;
                if (pass_done)
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_write = 1'b1;
                cmd.rd_issue    = !stat.issue_done;
                if (pass_done)
                begin
                    cmd.deq_finish = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold the result until the output slot frees
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/min_priority_request_queue.sv @@
// min_priority_request_queue: top level, joins the controller and the datapath.
// Depends on mprq_pkg, mprq_ctrl and mprq_dp.
`timescale 1ns / 1ps

// Holds up to DEPTH entries (data word and signed priority) in arrival order in a
// single-port-write, single-port-read memory. An enqueue or a rejected request
// (full or empty) goes straight to the emit state and raises out_valid once the
// output slot is free. A dequeue makes two passes over the stored entries before
// its emit: the memory read port visits one entry per cycle, first to find the
// lowest priority (oldest wins ties), then to move the younger entries down one
// slot. One item is worked on at a time; a finished result waits in the output
// register while the next item is taken.
module min_priority_request_queue
    import mprq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      opcode,
    input  logic signed [DATA_W-1:0]  req_data,
    input  logic signed [PRIO_W-1:0]  req_priority,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic        [1:0]         status,
    output logic signed [DATA_W-1:0]  out_data,
    output logic signed [PRIO_W-1:0]  out_priority,
    output logic        [COUNT_W-1:0] count
);

    mprq_cmd_t  cmd;
    mprq_stat_t stat;

    mprq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mprq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_data     (req_data),
        .req_priority (req_priority),
        .status       (status),
        .out_data     (out_data),
        .out_priority (out_priority),
        .count        (count)
    );

endmodule

@@ hw/rtl/mprq_checker.sv @@
// mprq_checker: port-level assertions for min_priority_request_queue, bound to the top.
// Depends on mprq_pkg.
`timescale 1ns / 1ps

module mprq_checker
    import mprq_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      opcode,
    input logic signed [DATA_W-1:0]  req_data,
    input logic signed [PRIO_W-1:0]  req_priority,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic        [1:0]         status,
    input logic signed [DATA_W-1:0]  out_data,
    input logic signed [PRIO_W-1:0]  out_priority,
    input logic        [COUNT_W-1:0] count
);

    // a waiting request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(req_data)
            && $stable(req_priority))
        else $error("waiting request changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_data)
            && $stable(out_priority) && $stable(count))
        else $error("stalled result changed");

    // one item at a time: no transfer on the cycle right after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> count == '0)
        else $error("empty status with nonzero count");

    a_reject_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_EMPTY)
            |-> out_data == NONE_DATA && out_priority == NONE_PRIORITY)
        else $error("rejected request carries entry data");

endmodule

bind min_priority_request_queue mprq_checker u_mprq_checker (.*);

@@ dv/min_priority_request_queue_tb.sv @@
// min_priority_request_queue_tb: self-checking bench for the min-priority request queue.
// A shadow queue predicts every response; needs mprq_pkg and min_priority_request_queue.
`timescale 1ns / 1ps

module min_priority_request_queue_tb
    import mprq_pkg::*;
;

    localparam int QUEUE_DEPTH = 64;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 20;
    localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
    } queue_entry_t;

    typedef struct {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic signed [PRIO_W-1:0] prio;
        logic [COUNT_W-1:0]       count;
    } queue_response_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      opcode = OP_ENQ;
    logic signed [DATA_W-1:0]  req_data = '0;
    logic signed [PRIO_W-1:0]  req_priority = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic        [1:0]         status;
    logic signed [DATA_W-1:0]  out_data;
    logic signed [PRIO_W-1:0]  out_priority;
    logic        [COUNT_W-1:0] count;

    queue_entry_t    shadow_entries[$];
    queue_response_t expected_responses[$];
    int              errors = 0;
    bit              sender_pauses = 1'b1;
    bit              sink_stalls = 1'b1;
    int unsigned     stall_left = 0;

    min_priority_request_queue #(.DEPTH(QUEUE_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .req_data     (req_data),
        .req_priority (req_priority),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_data     (out_data),
        .out_priority (out_priority),
        .count        (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no pause, some short ones, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom;
        else if (r < 80)
            return $signed(PRIO_W'($urandom_range(0, 8))) - 4;   // crowd into ties
        else if (r < 90)
            return PRIO_MAX;
        return PRIO_MIN;
    endfunction

    // Apply one request to the shadow queue and return the response it must give.
    function automatic queue_response_t predict_queue_op(logic op,
                                                         logic signed [DATA_W-1:0] data,
                                                         logic signed [PRIO_W-1:0] prio);
        queue_response_t rsp;
        queue_entry_t    ent;
        int              best;
        rsp.status = ST_DONE;
        rsp.data   = NONE_DATA;
        rsp.prio   = NONE_PRIORITY;
        if (op == OP_ENQ) begin
            if (shadow_entries.size() >= QUEUE_DEPTH) begin
                rsp.status = ST_FULL;
            end
            else begin
                ent.data = data;
                ent.prio = prio;
                shadow_entries.push_back(ent);
            end
        end
        else if (shadow_entries.size() == 0) begin
            rsp.status = ST_EMPTY;
        end
        else begin
            // Strict less-than keeps the oldest entry among equal priorities.
            best = 0;
            for (int i = 1; i < shadow_entries.size(); i++) begin
                if (shadow_entries[i].prio < shadow_entries[best].prio)
                    best = i;
            end
            rsp.data = shadow_entries[best].data;
            rsp.prio = shadow_entries[best].prio;
            shadow_entries.delete(best);
        end
        rsp.count = COUNT_W'(shadow_entries.size());
        return rsp;
    endfunction

    // Drive one request from a falling edge and hold it until the transfer.
    task automatic send_request(input logic op,
                                input logic signed [DATA_W-1:0] data,
                                input logic signed [PRIO_W-1:0] prio);
        int unsigned gap;
        gap = sender_pauses ? pick_gap() : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        req_data     <= data;
        req_priority <= prio;
        do
            @(posedge clk);
        while (!in_ready);
        expected_responses.push_back(predict_queue_op(op, data, prio));
    endtask

    task automatic test_empty_store();
        send_request(OP_DEQ, DATA_MAX, PRIO_MIN);
        send_request(OP_DEQ, '0, '0);
    endtask

    // Every priority at the maximum: the oldest must come out first.
    task automatic test_equal_max_priority();
        send_request(OP_ENQ, DATA_MAX, PRIO_MAX);
        send_request(OP_ENQ, DATA_MIN, PRIO_MAX);
        send_request(OP_ENQ, -1, PRIO_MAX);
        repeat (4) send_request(OP_DEQ, $urandom, $urandom);
    endtask

    task automatic test_priority_extremes();
        send_request(OP_ENQ, 0, PRIO_MIN);
        send_request(OP_ENQ, 1, 0);
        send_request(OP_ENQ, 2, PRIO_MIN);
        send_request(OP_ENQ, 3, -1);
        send_request(OP_ENQ, 4, PRIO_MAX);
        repeat (5) send_request(OP_DEQ, $urandom, $urandom);
    endtask

    // Fill to the top, push against it, then drain past empty.
    task automatic test_full_store();
        while (shadow_entries.size() < QUEUE_DEPTH)
            send_request(OP_ENQ, $urandom, pick_priority());
        repeat (3) send_request(OP_ENQ, $urandom, pick_priority());
        while (shadow_entries.size() != 0)
            send_request(OP_DEQ, $urandom, $urandom);
        repeat (2) send_request(OP_DEQ, $urandom, $urandom);
    endtask

    // Bursts with a shifting enqueue share walk the fill level up and down.
    task automatic test_mixed_traffic(input int n_items);
        int unsigned enq_pct;
        logic        op;
        enq_pct = 50;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0: enq_pct = 15;
                    1: enq_pct = 50;
                    2: enq_pct = 70;
                    default: enq_pct = 92;
                endcase
            end
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            send_request(op, $urandom, pick_priority());
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        sender_pauses = 1'b0;
        sink_stalls   = 1'b0;
        test_mixed_traffic(n_items);
        sender_pauses = 1'b1;
        sink_stalls   = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (!sink_stalls) begin
            out_ready <= 1'b1;
        end
        else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else begin
            out_ready  <= 1'b1;
            stall_left <= ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : response_check
        queue_response_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_responses.size() == 0) begin
                errors++;
                $display("%0t: response with none expected: status %h data %h prio %h count %h",
                         $time, status, out_data, out_priority, count);
            end
            else begin
                want = expected_responses.pop_front();
                check_field("status", want.status, status);
                check_field("out_data", want.data, out_data);
                check_field("out_priority", want.prio, out_priority);
                check_field("count", want.count, count);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_store();
        test_equal_max_priority();
        test_priority_extremes();
        test_full_store();
        test_mixed_traffic(1200);
        test_back_to_back(350);

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mprq_pkg.sv
hw/rtl/mprq_dp.sv
hw/rtl/mprq_ctrl.sv
hw/rtl/min_priority_request_queue.sv
hw/rtl/mprq_checker.sv
dv/min_priority_request_queue_tb.sv
